/* rtl/ppp_pkg.sv */
package ppp_pkg;

	// camera coefficients are always signed 32-bit fixed point
	localparam int COEF_W     = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int ROWS_W     = 16;
	localparam int NUM_MREGS  = 6;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ROW0_A     = 3'd0,
		REG_ROW0_B     = 3'd1,
		REG_ROW1_A     = 3'd2,
		REG_ROW1_B     = 3'd3,
		REG_ROW2_A     = 3'd4,
		REG_ROW2_B     = 3'd5,
		REG_IMAGE_ROWS = 3'd6
	} reg_idx_t;

	localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd480;

	typedef enum logic [1:0] {
		ST_FRONT  = 2'd0,
		ST_ZERO   = 2'd1,
		ST_BEHIND = 2'd2
	} proj_status_t;

endpackage

/* rtl/pinhole_point_projection.sv */
// Pinhole point projection: each input word is a homogeneous world point (x, y, z, w) in
// signed fixed point; it goes through the preloaded 3x4 camera matrix to give optical
// numerators u, v and depth d, then u/d and v/d are taken to pixel axes: column is v/d,
// row is (image_rows - 1) - u/d, both saturated to the coordinate range. Status tells
// a point in front, at zero depth (column and row then 0) or behind the camera.
// The block takes one point per clock while the output is not stalled, and returns one
// result word per point, in order. The pipeline has 2 stages of multiply and sum, 1
// magnitude stage, max(COORD_WIDTH, 16 + FRAC_BITS) + 3 divider stages (a head stage,
// then one quotient bit each, u and v in parallel sharing the depth) and 2 output stages.
// Each stage holds its word while the next is full, so a stalled output does not stop
// new points entering until every stage is occupied. The user must write the matrix and
// image_rows via the cfg port while the pipeline is empty; the block does not enforce it.
module pinhole_point_projection import ppp_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	localparam int IN_W       = ((4 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W      = ((2 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// point_x, point_y, point_z, point_w, zero pad
	input  logic [IN_W-1:0]           s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// pixel_col, pixel_row, proj_status, zero pad
	output logic [OUT_W-1:0]          m_tdata
);

	localparam int CW    = COORD_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int SW    = CW + COEF_W + 2;
	// quotient bits kept; anything larger saturates either output anyway
	localparam int Q     = ((CW > 16 + FB) ? CW : 16 + FB) + 2;
	localparam int RW    = Q + 3;
	localparam int NS    = Q + 6;
	localparam int DIV0  = 3;
	localparam int ST4   = Q + 4;
	localparam int ST5   = Q + 5;

	localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (CW - 1)));

	// configuration registers
	logic [NUM_MREGS-1:0][CFG_DATA_W-1:0] mat_q;
	logic [ROWS_W-1:0]                    rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q  <= '0;
			rows_q <= ROWS_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == REG_IMAGE_ROWS) begin
				rows_q <= cfg_data[ROWS_W-1:0];
			end else if (cfg_addr < REG_IMAGE_ROWS) begin
				mat_q[cfg_addr] <= cfg_data;
			end
		end
	end

	logic [2:0][3:0][COEF_W-1:0] coef;
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = mat_q[2*r][COEF_W-1:0];
			coef[r][1] = mat_q[2*r][2*COEF_W-1:COEF_W];
			coef[r][2] = mat_q[2*r+1][COEF_W-1:0];
			coef[r][3] = mat_q[2*r+1][2*COEF_W-1:COEF_W];
		end
	end

	// valid bits and per-stage advance, a stage moves when it is empty or its successor moves
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? s_tvalid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];

	// matrix times point
	logic [3:0][CW-1:0] point;
	logic [2:0][SW-1:0] dot;

	assign point = s_tdata[4*CW-1:0];

	ppp_dot #(.CW(CW), .SW(SW)) u_dot (
		.clk   (clk),
		.adv   (en[1:0]),
		.point (point),
		.coef  (coef),
		.dot   (dot)
	);

	// magnitudes and signs
	logic [SW-1:0] mag_u_s3, mag_v_s3, mag_d_s3;
	logic          neg_x_s3, neg_y_s3, dneg_s3, zero_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mag_u_s3 <= dot[0][SW-1] ? -dot[0] : dot[0];
			mag_v_s3 <= dot[1][SW-1] ? -dot[1] : dot[1];
			mag_d_s3 <= dot[2][SW-1] ? -dot[2] : dot[2];
			neg_x_s3 <= dot[0][SW-1] ^ dot[2][SW-1];
			neg_y_s3 <= dot[1][SW-1] ^ dot[2][SW-1];
			dneg_s3  <= dot[2][SW-1];
			zero_s3  <= dot[2] == '0;
		end
	end

	// two dividers running side by side on the shared depth
	logic [Q-1:0] quo_x, quo_y;
	logic         ovf_x, ovf_y;
	logic         tag_x;
	logic [2:0]   tag_y;

	ppp_div #(.SW(SW), .FB(FB), .Q(Q), .TAG_W(1)) u_div_x (
		.clk     (clk),
		.adv     (en[DIV0+Q:DIV0]),
		.num     (mag_u_s3),
		.den     (mag_d_s3),
		.tag_in  (neg_x_s3),
		.quo     (quo_x),
		.ovf     (ovf_x),
		.tag_out (tag_x)
	);

	ppp_div #(.SW(SW), .FB(FB), .Q(Q), .TAG_W(3)) u_div_y (
		.clk     (clk),
		.adv     (en[DIV0+Q:DIV0]),
		.num     (mag_v_s3),
		.den     (mag_d_s3),
		.tag_in  ({zero_s3, dneg_s3, neg_y_s3}),
		.quo     (quo_y),
		.ovf     (ovf_y),
		.tag_out (tag_y)
	);

	// signed quotients, overflow pinned just past the useful range
	logic [Q:0]            qmag_x, qmag_y;
	logic signed [Q+1:0]   qx_s4, qy_s4;
	logic                  zero_s4, dneg_s4;

	assign qmag_x = ovf_x ? {1'b1, {Q{1'b0}}} : {1'b0, quo_x};
	assign qmag_y = ovf_y ? {1'b1, {Q{1'b0}}} : {1'b0, quo_y};

	always_ff @(posedge clk) begin
		if (en[ST4]) begin
			qx_s4   <= tag_x    ? -$signed({1'b0, qmag_x}) : $signed({1'b0, qmag_x});
			qy_s4   <= tag_y[0] ? -$signed({1'b0, qmag_y}) : $signed({1'b0, qmag_y});
			dneg_s4 <= tag_y[1];
			zero_s4 <= tag_y[2];
		end
	end

	// axis flip and saturation
	logic signed [RW-1:0] base, row_w, col_w, row_sat, col_sat;

	assign base  = (RW'($signed({1'b0, rows_q})) - RW'(1)) <<< FB;
	assign row_w = base - RW'(qx_s4);
	assign col_w = RW'(qy_s4);

	always_comb begin
		row_sat = row_w;
		if (row_w > SAT_HI) row_sat = SAT_HI;
		else if (row_w < SAT_LO) row_sat = SAT_LO;
		col_sat = col_w;
		if (col_w > SAT_HI) col_sat = SAT_HI;
		else if (col_w < SAT_LO) col_sat = SAT_LO;
	end

	logic [CW-1:0]  col_s5, row_s5;
	proj_status_t   status_s5;

	always_ff @(posedge clk) begin
		if (en[ST5]) begin
			if (zero_s4) begin
				col_s5    <= '0;
				row_s5    <= '0;
				status_s5 <= ST_ZERO;
			end else begin
				col_s5    <= col_sat[CW-1:0];
				row_s5    <= row_sat[CW-1:0];
				status_s5 <= dneg_s4 ? ST_BEHIND : ST_FRONT;
			end
		end
	end

	assign m_tdata = OUT_W'({status_s5, row_s5, col_s5});

endmodule

/* rtl/ppp_dot.sv */
module ppp_dot import ppp_pkg::*; #(
	parameter int CW = 32,
	parameter int SW = CW + COEF_W + 2
) (
	input  logic                               clk,
	input  logic [1:0]                         adv,
	input  logic [3:0][CW-1:0]                 point,
	input  logic [2:0][3:0][COEF_W-1:0]        coef,
	output logic [2:0][SW-1:0]                 dot
);

	localparam int PW = CW + COEF_W;

	logic [2:0][3:0][PW-1:0] prod_s1;
	logic [2:0][SW-1:0]      dot_s2;

	// one multiplier per coefficient
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= $signed(coef[r][c]) * $signed(point[c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int r = 0; r < 3; r++) begin
				dot_s2[r] <= SW'($signed(prod_s1[r][0])) + SW'($signed(prod_s1[r][1]))
					+ SW'($signed(prod_s1[r][2])) + SW'($signed(prod_s1[r][3]));
			end
		end
	end

	assign dot = dot_s2;

endmodule

/* rtl/ppp_div.sv */
module ppp_div #(
	parameter int SW    = 66,
	parameter int FB    = 16,
	parameter int Q     = 34,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic [Q:0]       adv,
	input  logic [SW-1:0]    num,
	input  logic [SW-1:0]    den,
	input  logic [TAG_W-1:0] tag_in,
	output logic [Q-1:0]     quo,
	output logic             ovf,
	output logic [TAG_W-1:0] tag_out
);

	localparam int NW = SW + FB;
	localparam int HW = NW - Q;

	logic [NW-1:0] nsh;
	logic [HW-1:0] nhi;

	logic [SW-1:0]    rem_s [Q+1];
	logic [Q-1:0]     low_s [Q+1];
	logic [Q-1:0]     quo_s [Q+1];
	logic [SW-1:0]    den_s [Q+1];
	logic             ovf_s [Q+1];
	logic [TAG_W-1:0] tag_s [Q+1];

	assign nsh = {num, {FB{1'b0}}};
	assign nhi = nsh[NW-1:Q];

	// head stage: quotient too big for Q bits shows as high part >= divisor
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0] <= SW'(nhi);
			low_s[0] <= nsh[Q-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= SW'(nhi) >= den;
			tag_s[0] <= tag_in;
		end
	end

	// one restoring step per stage
	for (genvar k = 1; k <= Q; k++) begin : g_step
		logic [SW:0]   trial;
		logic [SW+1:0] sub;
		logic          ge;

		assign trial = {rem_s[k-1], low_s[k-1][Q-1]};
		assign sub   = {1'b0, trial} - {2'b00, den_s[k-1]};
		assign ge    = !sub[SW+1];

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k] <= ge ? sub[SW-1:0] : trial[SW-1:0];
				low_s[k] <= {low_s[k-1][Q-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][Q-2:0], ge};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign quo     = quo_s[Q];
	assign ovf     = ovf_s[Q];
	assign tag_out = tag_s[Q];

endmodule

/* verif/pinhole_point_projection_tb.sv */
module pinhole_point_projection_tb;
	import ppp_pkg::*;

	// stream widths: four 32-bit coordinates in, two 32-bit pixels plus 2-bit status out
	localparam int PT_W      = 128;
	localparam int PX_W      = 72;
	localparam int ONE_Q     = 32'h0001_0000;  // 1.0 in Q16.16
	localparam int N_RANDOM  = 150;            // points per random phase
	localparam int SETTLE    = 60;             // a little over the pipeline depth
	localparam int HOLD_LONG = 400;            // receiver back-pressure stretch
	localparam int STALL_MAX = 5000;
	// an index with no register behind it, writes there must be dropped
	localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic signed [31:0] x, y, z, w;
	} point_t;

	// packed from the top down, so col sits in the lowest bits as on the bus
	typedef struct packed {
		proj_status_t       status;
		logic signed [31:0] row;
		logic signed [31:0] col;
	} pixel_t;

	typedef struct {
		bit     use_ident;  // identity camera instead of the reset one
		point_t pt;
		bit     typed;      // expectation typed in rather than predicted
		pixel_t px;
	} vec_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// point_x, point_y, point_z, point_w
	logic [PT_W-1:0]       s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// pixel_col, pixel_row, proj_status, zero pad
	logic [PX_W-1:0]       m_tdata;

	// camera state as the block should hold it
	logic [63:0] cam_reg [NUM_MREGS];
	logic [15:0] img_rows;

	pixel_t pending_px[$];
	int     n_errors    = 0;
	int     n_points    = 0;
	int     n_pixels    = 0;
	int     n_status[3] = '{0, 0, 0};
	int     stall_cnt   = 0;
	bit     no_idle     = 1'b0;
	bit     hold_req    = 1'b0;
	int     hold_left   = 0;

	pinhole_point_projection u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one row of the camera matrix against the point, exact in 128 bits
	function automatic logic signed [127:0] cam_dot(int r, point_t p);
		logic signed [127:0] acc;
		logic signed [127:0] k;
		logic signed [127:0] v;
		logic signed [31:0]  half;
		logic [63:0]         rg;
		acc = '0;
		for (int c = 0; c < 4; c++) begin
			rg   = cam_reg[r * 2 + c / 2];
			half = (c % 2) ? rg[63:32] : rg[31:0];
			k    = half;
			case (c)
				0: v = p.x;
				1: v = p.y;
				2: v = p.z;
				default: v = p.w;
			endcase
			acc = acc + k * v;
		end
		return acc;
	endfunction

	// (num << frac) / den on magnitudes, truncated toward zero, clamped at 2^62
	function automatic logic signed [127:0] fx_div(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0]        n, d, q;
		logic signed [127:0] m;
		n = num[127] ? -num : num;
		d = den[127] ? -den : den;
		q = (n << 16) / d;
		if (q >= (128'd1 << 62))
			q = 128'd1 << 62;
		m = q;
		return (num[127] != den[127]) ? -m : m;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -128'sh8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic pixel_t project_point(point_t p);
		logic signed [127:0] u, v, d, base;
		pixel_t px;
		u = cam_dot(0, p);
		v = cam_dot(1, p);
		d = cam_dot(2, p);
		if (d == 0) begin
			px.col    = '0;
			px.row    = '0;
			px.status = ST_ZERO;
		end else begin
			base      = {112'd0, img_rows};
			base      = (base - 1) * 65536;
			px.col    = sat32(fx_div(v, d));
			px.row    = sat32(base - fx_div(u, d));
			px.status = d[127] ? ST_BEHIND : ST_FRONT;
		end
		return px;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on word %0d: %s got %h want %h", n_pixels, what, got, want);
		n_errors++;
	endtask

	// write enable stays up across back-to-back writes, load_camera drops it
	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx < NUM_MREGS)
			cam_reg[idx] = val;
		else if (idx == REG_IMAGE_ROWS)
			img_rows = val[15:0];
	endtask

	// registers in index order, then a stray write that must leave everything alone
	task automatic load_camera(logic [63:0] m[NUM_MREGS], logic [15:0] rows);
		write_reg(REG_ROW0_A, m[0]);
		write_reg(REG_ROW0_B, m[1]);
		write_reg(REG_ROW1_A, m[2]);
		write_reg(REG_ROW1_B, m[3]);
		write_reg(REG_ROW2_A, m[4]);
		write_reg(REG_ROW2_B, m[5]);
		write_reg(REG_IMAGE_ROWS, {48'd0, rows});
		write_reg(REG_NONE, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// pipeline empty: every word back, then a margin for the stages
	task automatic drain();
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_point(point_t p, bit typed, pixel_t px);
		s_tdata  <= {p.w, p.z, p.y, p.x};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_px.push_back(typed ? px : project_point(p));
		n_points++;
		if (!no_idle && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] small_coef();
		// a few units either side of zero, as a real intrinsic-times-pose product
		return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
	endfunction

	function automatic point_t rand_point(bit wild);
		point_t p;
		if (wild || $urandom_range(99) < 20) begin
			p = {$urandom, $urandom, $urandom, $urandom};
		end else begin
			p.x = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
			p.y = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
			p.z = $urandom_range(0, 32'h0080_0000) - 32'h0020_0000;
			p.w = ONE_Q;
		end
		return p;
	endfunction

	// result side: check each word, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[65:0];
				if (pending_px.size() == 0) begin
					$display("unexpected word %0d: %h", n_pixels, m_tdata);
					n_errors++;
				end else begin
					want = pending_px.pop_front();
					if (got.col !== want.col)
						report_mismatch("pixel_col", got.col, want.col);
					if (got.row !== want.row)
						report_mismatch("pixel_row", got.row, want.row);
					if (got.status !== want.status)
						report_mismatch("proj_status", got.status, want.status);
					if (m_tdata[PX_W-1:66] !== '0)
						report_mismatch("pad", m_tdata[PX_W-1:66], 0);
					if (want.status <= ST_BEHIND)
						n_status[want.status]++;
				end
				n_pixels++;
			end
			if (hold_req) begin
				hold_left = HOLD_LONG;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= 29);
			end
		end
	end

	// watchdog on cycles where neither side moves a word
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > STALL_MAX) begin
			$display("timeout with %0d words outstanding", pending_px.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		vec_t        dir_tab[$];
		vec_t        vc;
		logic [63:0] m[NUM_MREGS];
		logic [63:0] ident[NUM_MREGS];
		pixel_t      zero_px;
		pixel_t      dummy;
		bit          cur_ident;
		logic [15:0] rows;

		foreach (cam_reg[i])
			cam_reg[i] = '0;
		img_rows = ROWS_RESET;
		zero_px  = '{col: '0, row: '0, status: ST_ZERO};
		dummy    = zero_px;
		// unit focal length, camera at the origin: m00 = m11 = m22 = 1.0
		ident    = '{{32'd0, ONE_Q}, 64'd0, {ONE_Q, 32'd0}, 64'd0, 64'd0, {32'd0, ONE_Q}};

		// reset camera is all zero, so every point lands at zero depth
		dir_tab.push_back('{0, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF}, 1, zero_px});
		dir_tab.push_back('{0, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000}, 1, zero_px});
		dir_tab.push_back('{0, '{0, 0, 0, 0}, 1, zero_px});
		dir_tab.push_back('{0, '{-1, -1, -1, -1}, 1, zero_px});
		// identity camera from here on
		dir_tab.push_back('{1, '{0, 0, ONE_Q, ONE_Q}, 0, dummy});
		dir_tab.push_back('{1, '{ONE_Q, 2 * ONE_Q, ONE_Q, ONE_Q}, 0, dummy});
		dir_tab.push_back('{1, '{5 * ONE_Q, -3 * ONE_Q, 0, ONE_Q}, 1, zero_px});
		dir_tab.push_back('{1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh7FFF_FFFF}, 1,
			zero_px});
		// behind the camera
		dir_tab.push_back('{1, '{ONE_Q, ONE_Q, -ONE_Q, ONE_Q}, 0, dummy});
		dir_tab.push_back('{1, '{32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0}, 0, dummy});
		// tiny depths saturate both pixels in the first two; the rest have larger depths
		dir_tab.push_back('{1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0}, 0, dummy});
		dir_tab.push_back('{1, '{32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0}, 0, dummy});
		dir_tab.push_back('{1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0}, 0,
			dummy});
		dir_tab.push_back('{1, '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0}, 0,
			dummy});
		dir_tab.push_back('{1, '{32'sh0000_8000, -32'sh0000_8000, 3 * ONE_Q, -ONE_Q}, 0,
			dummy});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table, camera switched once between the two groups
		cur_ident = 1'b0;
		foreach (dir_tab[i]) begin
			vc = dir_tab[i];
			if (vc.use_ident != cur_ident) begin
				s_tvalid <= 1'b0;
				drain();
				load_camera(ident, ROWS_RESET);
				cur_ident = vc.use_ident;
			end
			send_point(vc.pt, vc.typed, vc.px);
		end
		s_tvalid <= 1'b0;
		drain();

		// random phases, each with its own camera and image height
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					foreach (m[i]) m[i] = {small_coef(), small_coef()};
					rows = 16'($urandom_range(1, 2000));
				end
				1: begin
					// zero height: row offset becomes minus one
					foreach (m[i]) m[i] = {small_coef(), small_coef()};
					rows = 16'd0;
				end
				2: begin
					foreach (m[i]) m[i] = $urandom_range(1) ? 64'h7FFF_FFFF_7FFF_FFFF
						: 64'h8000_0000_8000_0000;
					rows = 16'hFFFF;
				end
				3: begin
					foreach (m[i]) m[i] = {small_coef(), small_coef()};
					rows = 16'd1;
				end
				4: begin
					foreach (m[i]) m[i] = {$urandom, $urandom};
					rows = 16'($urandom);
				end
				default: begin
					// depth row blanked out, every point at zero depth
					foreach (m[i]) m[i] = {small_coef(), small_coef()};
					m[4] = '0;
					m[5] = '0;
					rows = ROWS_RESET;
				end
			endcase
			load_camera(m, rows);
			no_idle = (ph == 3);
			if (ph == 1)
				hold_req = 1'b1;  // receiver goes quiet while points keep coming
			for (int k = 0; k < N_RANDOM; k++)
				send_point(rand_point(ph >= 4), 1'b0, dummy);
			s_tvalid <= 1'b0;
			drain();
		end
		no_idle = 1'b0;

		$display("%0d points projected across 8 camera settings, %0d words returned",
			n_points, n_pixels);
		$display("status counts: front %0d, zero depth %0d, behind %0d, %0d mismatches",
			n_status[0], n_status[1], n_status[2], n_errors);
		if (n_errors == 0 && pending_px.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
